### hdl/word_break_checker_core_assert.svh
// Assertion macros used by the word break checker port checker (wbc_checker).
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef WORD_BREAK_CHECKER_CORE_ASSERT_SVH
`define WORD_BREAK_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wbc_pkg.sv
// Shared constants, field layout and request codes of the word break checker.
// No dependencies; imported by the core and the port checker.
`timescale 1ns / 1ps

package wbc_pkg;

  // Dictionary geometry
  localparam int NumWords   = 16;
  localparam int MaxWordLen = 16;

  // Field widths of the stream requests and results
  localparam int OpW         = 2;
  localparam int WordIdxFldW = 4;
  localparam int CharPosFldW = 4;
  localparam int WordLenFldW = 5;
  localparam int CharW       = 8;
  localparam int PosW        = 16;
  localparam int KindW       = 1;

  // Input tdata: word_index, char_pos, word_length, char_value, low bits first
  localparam int WordIdxLsb  = 0;
  localparam int CharPosLsb  = WordIdxLsb + WordIdxFldW;
  localparam int WordLenLsb  = CharPosLsb + CharPosFldW;
  localparam int CharValLsb  = WordLenLsb + WordLenFldW;
  localparam int InUsedW     = CharValLsb + CharW;
  localparam int InDataW     = ((InUsedW + 7) / 8) * 8;

  // Output tdata: breakable, position, low bits first
  localparam int OutUsedW    = 1 + PosW;
  localparam int OutDataW    = ((OutUsedW + 7) / 8) * 8;

  // Derived storage widths
  localparam int LenW     = $clog2(MaxWordLen + 1);
  localparam int SegW     = MaxWordLen + 1;
  localparam int RowW     = MaxWordLen * CharW;
  localparam int WordIdxW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int CharPosW = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // Request codes carried in s_axis_tuser
  localparam logic [OpW-1:0] OP_LOAD_CHAR = 2'd0;
  localparam logic [OpW-1:0] OP_SET_LEN   = 2'd1;
  localparam logic [OpW-1:0] OP_TEXT_CHAR = 2'd2;
  localparam logic [OpW-1:0] OP_END       = 2'd3;

  // Result kinds carried in m_axis_tuser
  localparam logic [KindW-1:0] KIND_PREFIX = 1'b0;
  localparam logic [KindW-1:0] KIND_FINAL  = 1'b1;

endpackage

### hdl/wbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module wbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/word_break_checker_core.sv
// Word break checker core: dictionary RAM plus a scan sequencer per text character.
// Depends on wbc_pkg and wbc_ram.
`timescale 1ns / 1ps

// Decides whether a streamed text splits into words of a loaded dictionary.
// Requests arrive on the s_axis side with the request code in tuser: load a
// dictionary character, set an entry length (0 disables the entry, lengths
// above MaxWordLen saturate), a text character, or end of string. Text
// characters and end of string each return one result on m_axis: tuser 0 is
// the prefix answer after a character, tuser 1 the answer for the whole string,
// after which the string restarts (the dictionary is kept; an empty string
// answers breakable). A text character walks every dictionary entry, one RAM
// row read per cycle, and holds the core through the scan, a step to fold in
// the last entry (ST_FINISH) and a step to move the result to the output register
// (ST_EMIT), which waits while an earlier result is still held; a character load
// is a read-modify-write of one RAM row; a length load is written directly; an
// end of string only moves its result to the output register. A result waiting
// in the output register does not stop the next request from being taken; only
// the next result waits behind it. The dictionary RAM needs no clearing after
// reset: characters of an entry are only compared up to its length, and lengths
// reset to zero.
module word_break_checker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // word_index[3:0], char_pos[7:4], word_length[12:8], char_value[20:13], zero pad
  input  logic [wbc_pkg::InDataW-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  logic [wbc_pkg::OpW-1:0]       s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // breakable[0], position[16:1], zero pad
  output logic [wbc_pkg::OutDataW-1:0]  m_axis_tdata,
  // result_kind[0]
  output logic [wbc_pkg::KindW-1:0]     m_axis_tuser
);

  import wbc_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LOAD_WR = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_FINISH  = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0]             state_q, state_d;

  logic                   s_acc;
  logic [OpW-1:0]         op;
  logic [WordIdxFldW-1:0] word_index;
  logic [CharPosFldW-1:0] char_pos;
  logic [WordLenFldW-1:0] word_length;
  logic [CharW-1:0]       char_value;
  logic                   idx_ok;
  logic                   pos_ok;
  logic [LenW-1:0]        len_sat;

  logic [LenW-1:0]        len_q [NumWords];
  logic [CharW-1:0]       recent_q [MaxWordLen];
  logic [SegW-1:0]        seg_q;
  logic [PosW-1:0]        count_q;

  logic [WordIdxW-1:0]    scan_idx_q;
  logic                   rd_vld_q;
  logic [LenW-1:0]        rd_len_q;
  logic                   hit_q;

  logic [WordIdxW-1:0]    ld_addr_q;
  logic [CharPosW-1:0]    ld_pos_q;
  logic [CharW-1:0]       ld_char_q;

  logic                   ram_we;
  logic                   ram_re;
  logic [WordIdxW-1:0]    ram_raddr;
  logic [RowW-1:0]        ram_wdata;
  logic [RowW-1:0]        rd_row;

  logic                   cmp_ok;
  logic                   entry_hit;
  logic                   scan_hit;

  logic [KindW-1:0]       res_kind_q;
  logic                   res_bit_q;
  logic [PosW-1:0]        res_pos_q;
  logic                   out_load;

  // Request decode
  assign op          = s_axis_tuser;
  assign word_index  = s_axis_tdata[WordIdxLsb +: WordIdxFldW];
  assign char_pos    = s_axis_tdata[CharPosLsb +: CharPosFldW];
  assign word_length = s_axis_tdata[WordLenLsb +: WordLenFldW];
  assign char_value  = s_axis_tdata[CharValLsb +: CharW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign idx_ok  = int'(word_index) < NumWords;
  assign pos_ok  = int'(char_pos) < MaxWordLen;
  assign len_sat = (int'(word_length) > MaxWordLen) ? LenW'(MaxWordLen)
                                                    : LenW'(word_length);

  // Dictionary RAM: one row per entry, character 0 in the low byte
  assign ram_re    = (s_acc && (op == OP_LOAD_CHAR)) || (state_q == ST_SCAN);
  assign ram_raddr = (state_q == ST_SCAN) ? scan_idx_q : WordIdxW'(word_index);
  assign ram_we    = (state_q == ST_LOAD_WR);

  always_comb begin
    ram_wdata = rd_row;
    ram_wdata[CharW*ld_pos_q +: CharW] = ld_char_q;
  end

  wbc_ram #(
    .Width(RowW),
    .Depth(NumWords)
  ) u_dict_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ld_addr_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_row)
  );

  // Compare the entry read last cycle, reversed, against the newest characters
  always_comb begin
    logic [LenW-1:0] pos_sel;
    cmp_ok  = 1'b1;
    pos_sel = '0;
    for (int t = 0; t < MaxWordLen; t++) begin
      pos_sel = rd_len_q - LenW'(t + 1);
      if ((LenW'(t) < rd_len_q) &&
          (rd_row[CharW*pos_sel[CharPosW-1:0] +: CharW] != recent_q[t])) begin
        cmp_ok = 1'b0;
      end
    end
  end

  assign entry_hit = rd_vld_q && (rd_len_q != '0) && (PosW'(rd_len_q) <= count_q) &&
                     cmp_ok && seg_q[rd_len_q - LenW'(1)];
  assign scan_hit  = hit_q || entry_hit;

  assign out_load = (state_q == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          case (op)
            OP_LOAD_CHAR: state_d = (idx_ok && pos_ok) ? ST_LOAD_WR : ST_IDLE;
            OP_SET_LEN:   state_d = ST_IDLE;
            OP_TEXT_CHAR: state_d = ST_SCAN;
            OP_END:       state_d = ST_EMIT;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_WR: state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_idx_q == WordIdxW'(NumWords - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_idx_q    <= '0;
      rd_vld_q      <= 1'b0;
      hit_q         <= 1'b0;
      seg_q         <= SegW'(1);
      count_q       <= '0;
      m_axis_tvalid <= 1'b0;
      for (int w = 0; w < NumWords; w++) begin
        len_q[w] <= '0;
      end
      for (int i = 0; i < MaxWordLen; i++) begin
        recent_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (rd_vld_q) begin
        hit_q <= scan_hit;
      end
      if (state_q == ST_SCAN) begin
        scan_idx_q <= scan_idx_q + WordIdxW'(1);
      end

      if (s_acc) begin
        case (op)
          OP_SET_LEN: begin
            if (idx_ok) begin
              len_q[WordIdxW'(word_index)] <= len_sat;
            end
          end
          OP_TEXT_CHAR: begin
            // Shift the window; the segment bits move only once the scan ends
            recent_q[0] <= char_value;
            for (int i = 1; i < MaxWordLen; i++) begin
              recent_q[i] <= recent_q[i-1];
            end
            if (count_q != PosMax) begin
              count_q <= count_q + PosW'(1);
            end
            scan_idx_q <= '0;
            hit_q      <= 1'b0;
          end
          OP_END: begin
            // Restart the string, keep the dictionary
            for (int i = 0; i < MaxWordLen; i++) begin
              recent_q[i] <= '0;
            end
            seg_q   <= SegW'(1);
            count_q <= '0;
          end
          default: ;
        endcase
      end

      if (state_q == ST_FINISH) begin
        seg_q <= {seg_q[SegW-2:0], scan_hit};
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_len_q <= len_q[scan_idx_q];
    if (s_acc) begin
      ld_addr_q <= WordIdxW'(word_index);
      ld_pos_q  <= CharPosW'(char_pos);
      ld_char_q <= char_value;
    end
    if (s_acc && (op == OP_END)) begin
      res_kind_q <= KIND_FINAL;
      res_bit_q  <= seg_q[0];
      res_pos_q  <= count_q;
    end
    if (state_q == ST_FINISH) begin
      res_kind_q <= KIND_PREFIX;
      res_bit_q  <= scan_hit;
      res_pos_q  <= count_q;
    end
    if (out_load) begin
      m_axis_tuser <= res_kind_q;
      m_axis_tdata <= OutDataW'({res_pos_q, res_bit_q});
    end
  end

endmodule

### hdl/wbc_checker.sv
// Port-level checks of the word break checker core, bound to its top level.
// Depends on wbc_pkg and word_break_checker_core_assert.svh.
`timescale 1ns / 1ps
`include "word_break_checker_core_assert.svh"

module wbc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [wbc_pkg::InDataW-1:0]   s_axis_tdata,
  input logic [wbc_pkg::OpW-1:0]       s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [wbc_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [wbc_pkg::KindW-1:0]     m_axis_tuser
);

  import wbc_pkg::*;

  // Hold a stalled result
  `WBC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // A text character starts a dictionary scan that blocks new requests
  `WBC_ASSERT_NEXT(a_scan_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TEXT_CHAR), !s_axis_tready, "request taken during dictionary scan")

  // A prefix result always follows at least one character
  `WBC_ASSERT_NOW(a_prefix_pos, m_axis_tvalid && (m_axis_tuser == KIND_PREFIX), m_axis_tdata[PosW:1] != '0, "prefix result at position zero")

  // An empty string splits trivially
  `WBC_ASSERT_NOW(a_empty_true, m_axis_tvalid && (m_axis_tuser == KIND_FINAL) && (m_axis_tdata[PosW:1] == '0), m_axis_tdata[0], "empty string not breakable")

endmodule

bind word_break_checker_core wbc_checker u_wbc_checker (.*);
